/* rtl/positional_list_store_unit_assert.svh */
// Assertion macros shared by the list store RTL.
// Used by plst_ctrl; depends on nothing else.
`ifndef POSITIONAL_LIST_STORE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_STORE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLST_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("plst assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PLST_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("plst assertion failed");

`endif

/* rtl/plst_pkg.sv */
// Package for the positional list store: sizes, request kinds, status codes
// and the structs passed between the controller, the RAM and the top level.
// Depends on nothing.
package plst_pkg;

    localparam int CAPACITY = 64;

    localparam int DATA_W = 32;
    localparam int KIND_W = 3;
    localparam int POS_W  = 6;
    localparam int LEN_W  = 7;
    localparam int STAT_W = 2;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int S_TDATA_W = ((POS_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + LEN_W + STAT_W + 7) / 8) * 8;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_PAST_END = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [LEN_W-1:0]         length;
        logic [STAT_W-1:0]        status;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

/* rtl/plst_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module plst_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/plst_ctrl.sv */
// Sequencer of the list store: decodes requests, runs the one-entry-per-cycle
// shift through the entry RAM and produces one result per request.
// Depends on plst_pkg and positional_list_store_unit_assert.svh.
`include "positional_list_store_unit_assert.svh"

module plst_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  plst_pkg::request_t              req,
    output plst_pkg::ram_req_t              ram_req,
    input  logic [plst_pkg::DATA_W-1:0]     ram_rdata,
    output logic                            res_valid,
    input  logic                            res_take,
    output plst_pkg::result_t               res
);

    localparam int ADDR_W = plst_pkg::ADDR_W;
    localparam int CNT_W  = plst_pkg::CNT_W;
    localparam int CMP_W  = plst_pkg::CMP_W;
    localparam int DATA_W = plst_pkg::DATA_W;
    localparam int LEN_W  = plst_pkg::LEN_W;
    localparam int STAT_W = plst_pkg::STAT_W;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(plst_pkg::CAPACITY);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MOVE  = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]               state_reg,    state_next;
    logic [CNT_W-1:0]         count_reg,    count_next;
    logic                     rd_go_reg,    rd_go_next;
    logic                     fly_reg,      fly_next;
    logic                     up_reg,       up_next;
    logic [ADDR_W-1:0]        rd_ptr_reg,   rd_ptr_next;
    logic [ADDR_W-1:0]        last_ptr_reg, last_ptr_next;
    logic [ADDR_W-1:0]        fly_addr_reg, fly_addr_next;
    logic [ADDR_W-1:0]        ins_pos_reg,  ins_pos_next;
    logic signed [DATA_W-1:0] ins_val_reg,  ins_val_next;
    logic signed [DATA_W-1:0] rd_val_reg,   rd_val_next;
    logic [STAT_W-1:0]        status_reg,   status_next;

    logic [CMP_W-1:0]  cnt_c;
    logic [CMP_W-1:0]  pos_c;
    logic [CNT_W-1:0]  cnt_m1;
    logic [ADDR_W-1:0] pos_a;
    logic [ADDR_W-1:0] tail_a;
    logic [ADDR_W-1:0] last_a;
    logic [ADDR_W-1:0] place_a;
    logic [ADDR_W-1:0] look_a;

    // Position and count compared at a common width.
    always_comb begin
        cnt_c   = CMP_W'(count_reg);
        pos_c   = CMP_W'(req.position);
        cnt_m1  = count_reg - CNT_W'(1);
        pos_a   = ADDR_W'(req.position);
        tail_a  = count_reg[ADDR_W-1:0];
        last_a  = cnt_m1[ADDR_W-1:0];
        place_a = ((req.kind == plst_pkg::KIND_APPEND) || (pos_c > cnt_c)) ? tail_a : pos_a;
        look_a  = (pos_c >= cnt_c) ? last_a : pos_a;
    end

    // Request decode and shift sequencing.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_go_next    = rd_go_reg;
        fly_next      = fly_reg;
        up_next       = up_reg;
        rd_ptr_next   = rd_ptr_reg;
        last_ptr_next = last_ptr_reg;
        fly_addr_next = fly_addr_reg;
        ins_pos_next  = ins_pos_reg;
        ins_val_next  = ins_val_reg;
        rd_val_next   = rd_val_reg;
        status_next   = status_reg;

        ram_req.we    = 1'b0;
        ram_req.waddr = fly_addr_reg;
        ram_req.wdata = ram_rdata;
        ram_req.raddr = rd_ptr_reg;

        req_ready = (state_reg == ST_IDLE);
        res_valid = (state_reg == ST_DONE);

        case (state_reg)
            ST_IDLE: begin
                ram_req.raddr = look_a;
                if (req_valid) begin
                    rd_val_next = '0;
                    status_next = plst_pkg::STAT_OK;
                    state_next  = ST_DONE;
                    case (req.kind)
                        plst_pkg::KIND_INSERT, plst_pkg::KIND_APPEND: begin
                            if (count_reg == CNT_FULL) begin
                                status_next = plst_pkg::STAT_FULL;
                            end else if (place_a == tail_a) begin
                                // Placing at the tail needs no shift.
                                ram_req.we    = 1'b1;
                                ram_req.waddr = place_a;
                                ram_req.wdata = req.value;
                                count_next    = count_reg + CNT_W'(1);
                            end else begin
                                rd_ptr_next   = last_a;
                                last_ptr_next = place_a;
                                ins_pos_next  = place_a;
                                ins_val_next  = req.value;
                                rd_go_next    = 1'b1;
                                up_next       = 1'b1;
                                state_next    = ST_MOVE;
                            end
                        end
                        plst_pkg::KIND_DELETE: begin
                            if (pos_c >= cnt_c) begin
                                status_next = plst_pkg::STAT_PAST_END;
                            end else if (pos_a == last_a) begin
                                count_next = cnt_m1;
                            end else begin
                                rd_ptr_next   = pos_a + ADDR_W'(1);
                                last_ptr_next = last_a;
                                rd_go_next    = 1'b1;
                                up_next       = 1'b0;
                                state_next    = ST_MOVE;
                            end
                        end
                        plst_pkg::KIND_READ: begin
                            if (count_reg == '0) begin
                                status_next = plst_pkg::STAT_EMPTY;
                            end else begin
                                state_next = ST_FETCH;
                            end
                        end
                        plst_pkg::KIND_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_MOVE: begin
                // Issue the next read of the shift, one entry per cycle.
                fly_next = rd_go_reg;
                if (rd_go_reg) begin
                    fly_addr_next = rd_ptr_reg;
                    if (rd_ptr_reg == last_ptr_reg) begin
                        rd_go_next = 1'b0;
                    end else if (up_reg) begin
                        rd_ptr_next = rd_ptr_reg - ADDR_W'(1);
                    end else begin
                        rd_ptr_next = rd_ptr_reg + ADDR_W'(1);
                    end
                end
                // Write back the entry read last cycle one place over.
                if (fly_reg) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = up_reg ? (fly_addr_reg + ADDR_W'(1))
                                           : (fly_addr_reg - ADDR_W'(1));
                end
                // Shift finished: place the new value or drop the last entry.
                if (!rd_go_reg && !fly_reg) begin
                    if (up_reg) begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = ins_pos_reg;
                        ram_req.wdata = ins_val_reg;
                        count_next    = count_reg + CNT_W'(1);
                    end else begin
                        count_next = cnt_m1;
                    end
                    state_next = ST_DONE;
                end
            end

            ST_FETCH: begin
                rd_val_next = ram_rdata;
                state_next  = ST_DONE;
            end

            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            rd_go_reg <= 1'b0;
            fly_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            rd_go_reg <= rd_go_next;
            fly_reg   <= fly_next;
        end
    end

    // Pointers and payload.
    always_ff @(posedge aclk) begin
        up_reg       <= up_next;
        rd_ptr_reg   <= rd_ptr_next;
        last_ptr_reg <= last_ptr_next;
        fly_addr_reg <= fly_addr_next;
        ins_pos_reg  <= ins_pos_next;
        ins_val_reg  <= ins_val_next;
        rd_val_reg   <= rd_val_next;
        status_reg   <= status_next;
    end

    assign res.read_value = rd_val_reg;
    assign res.length     = LEN_W'(count_reg);
    assign res.status     = status_reg;

    // The count never exceeds the capacity.
    `PLST_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_FULL)
    // A shift write never lands on the entry being read in the same cycle.
    `PLST_ASSERT_IMP(a_shift_no_overlap, aclk, aresetn, (state_reg == ST_MOVE) && ram_req.we && rd_go_reg, ram_req.waddr != ram_req.raddr)
    // An accepted request always leaves the idle state.
    `PLST_ASSERT_NXT(a_accept_busy, aclk, aresetn, req_valid && req_ready, state_reg != ST_IDLE)
    // A read is only fetched from a list that holds entries.
    `PLST_ASSERT_IMP(a_fetch_nonempty, aclk, aresetn, state_reg == ST_FETCH, count_reg != '0)

endmodule

/* rtl/positional_list_store_unit.sv */
// Positional list store: an ordered list of signed 32-bit entries in one RAM,
// built from plst_ctrl and plst_ram, with sizes and codes from plst_pkg.
// Tail appends, last-entry deletes, clears and rejected requests go straight to a
// result; a read first fetches its entry, a shift first moves each entry one place.
// One request at a time: the next is taken once the result enters the output register,
// which waits on m_tready. aresetn (synchronous) empties the list and drops any result.
module positional_list_store_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [plst_pkg::S_TDATA_W-1:0]     s_tdata,   // position, value, zero pad
    input  logic [plst_pkg::KIND_W-1:0]        s_tuser,   // kind
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [plst_pkg::M_TDATA_W-1:0]     m_tdata    // read_value, length, status, zero pad
);

    localparam int POS_W     = plst_pkg::POS_W;
    localparam int DATA_W    = plst_pkg::DATA_W;
    localparam int M_TDATA_W = plst_pkg::M_TDATA_W;

    plst_pkg::request_t req;
    plst_pkg::ram_req_t ram_req;
    plst_pkg::result_t  res;
    logic [DATA_W-1:0]  ram_rdata;
    logic               res_valid;
    logic               res_take;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg,  m_tdata_next;

    // Unpack the input transfer.
    assign req.kind     = s_tuser;
    assign req.position = s_tdata[POS_W-1:0];
    assign req.value    = s_tdata[POS_W +: DATA_W];

    plst_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    plst_ram #(
        .DEPTH  (plst_pkg::CAPACITY),
        .WIDTH  (DATA_W),
        .ADDR_W (plst_pkg::ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // Output register: loads a finished result whenever it is empty or draining.
    always_comb begin
        res_take      = res_valid && (!m_tvalid_reg || m_tready);
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_take) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'({res.status, res.length, res.read_value});
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for positional_list_store_unit: predicts every result
// from its own copy of the list and checks it. Depends on plst_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int KIND_W    = plst_pkg::KIND_W;
    localparam int POS_W     = plst_pkg::POS_W;
    localparam int DATA_W    = plst_pkg::DATA_W;
    localparam int LEN_W     = plst_pkg::LEN_W;
    localparam int STAT_W    = plst_pkg::STAT_W;
    localparam int CAPACITY  = plst_pkg::CAPACITY;
    localparam int S_TDATA_W = plst_pkg::S_TDATA_W;
    localparam int M_TDATA_W = plst_pkg::M_TDATA_W;

    // Kind codes that the block treats as no-ops.
    localparam logic [KIND_W-1:0] KIND_SPARE_LO  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_MID = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI  = 3'd7;

    // Mixes of request kinds used by the random part.
    localparam int MIX_GROW   = 0;
    localparam int MIX_SHRINK = 1;
    localparam int MIX_EVEN   = 2;

    localparam int RANDOM_ITEMS   = 1800;
    localparam int DRAIN_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT = 2000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the list, updated at each accepted input transfer.
    logic [DATA_W-1:0] list_mem [CAPACITY];
    int unsigned list_len = 0;

    plst_pkg::result_t pending_results[$];
    bit idle_enable = 1'b1;
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned error_count = 0;
    int unsigned requests_sent = 0;
    int unsigned results_checked = 0;
    int unsigned status_seen [4] = '{0, 0, 0, 0};

    positional_list_store_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // position, value, zero pad
        .s_tuser (s_tuser),   // kind
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)    // read_value, length, status, zero pad
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Applies one request to the shadow list and returns the result it must cause.
    function automatic plst_pkg::result_t apply_request(input logic [KIND_W-1:0] kind,
                                                        input logic [POS_W-1:0] pos,
                                                        input logic [DATA_W-1:0] val);
        plst_pkg::result_t r;
        int unsigned p;
        int unsigned k;
        r = '0;
        r.status = plst_pkg::STAT_OK;
        p = 32'(pos);
        case (kind)
            plst_pkg::KIND_INSERT, plst_pkg::KIND_APPEND: begin
                if (list_len >= CAPACITY) begin
                    r.status = plst_pkg::STAT_FULL;
                end else begin
                    if (kind == plst_pkg::KIND_APPEND || p > list_len) p = list_len;
                    for (k = list_len; k > p; k--) list_mem[k] = list_mem[k-1];
                    list_mem[p] = val;
                    list_len++;
                end
            end
            plst_pkg::KIND_DELETE: begin
                if (p >= list_len) begin
                    r.status = plst_pkg::STAT_PAST_END;
                end else begin
                    for (k = p; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
                    list_len--;
                end
            end
            plst_pkg::KIND_READ: begin
                if (list_len == 0) begin
                    r.status = plst_pkg::STAT_EMPTY;
                end else begin
                    if (p >= list_len) p = list_len - 1;
                    r.read_value = list_mem[p];
                end
            end
            plst_pkg::KIND_CLEAR: list_len = 0;
            default: ;
        endcase
        r.length = list_len[LEN_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] expected,
                                   input logic [DATA_W-1:0] actual);
        $display("%0t: mismatch on %s after %0d results: expected %0d, got %0d",
                 $time, what, results_checked, expected, actual);
        error_count++;
    endtask

    // Sends one request after an optional gap; the shadow list follows on acceptance.
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val);
        logic [S_TDATA_W-1:0] word;
        int unsigned gap;
        gap = idle_enable ? pick_gap() : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        word = '0;
        word[POS_W-1:0] = pos;
        word[POS_W +: DATA_W] = val;
        s_tvalid <= 1'b1;
        s_tdata <= word;
        s_tuser <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(apply_request(kind, pos, val));
        requests_sent++;
    endtask

    // Result side backpressure.
    always @(posedge aclk) begin
        if (!idle_enable) begin
            m_tready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Each result transfer is compared with the oldest pending expectation.
    always @(posedge aclk) begin
        plst_pkg::result_t got;
        plst_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.read_value = m_tdata[DATA_W-1:0];
            got.length = m_tdata[DATA_W +: LEN_W];
            got.status = m_tdata[DATA_W + LEN_W +: STAT_W];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, read_value", '0, got.read_value);
            end else begin
                want = pending_results.pop_front();
                if (got.read_value !== want.read_value)
                    report_mismatch("read_value", want.read_value, got.read_value);
                if (got.length !== want.length)
                    report_mismatch("length", DATA_W'(want.length), DATA_W'(got.length));
                if (got.status !== want.status)
                    report_mismatch("status", DATA_W'(want.status), DATA_W'(got.status));
                status_seen[want.status]++;
            end
            results_checked++;
        end
    end

    // Counts cycles in which neither side moves a transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Requests on an empty list, plus two of the spare kinds.
    task automatic test_empty_list();
        send_request(plst_pkg::KIND_READ, 6'd0, 32'h1234_5678);
        send_request(plst_pkg::KIND_READ, 6'd63, 32'hFFFF_FFFF);
        send_request(plst_pkg::KIND_DELETE, 6'd0, '0);
        send_request(plst_pkg::KIND_DELETE, 6'd63, '0);
        send_request(plst_pkg::KIND_CLEAR, 6'd63, 32'hFFFF_FFFF);
        send_request(KIND_SPARE_LO, 6'd0, 32'hA5A5_A5A5);
        send_request(KIND_SPARE_HI, 6'd63, 32'h5A5A_5A5A);
    endtask

    // Clamped insert and read, extreme values, delete past the end, a spare kind and clear.
    task automatic test_edge_positions();
        send_request(plst_pkg::KIND_INSERT, 6'd63, 32'h7FFF_FFFF);
        send_request(plst_pkg::KIND_APPEND, 6'd0, 32'h8000_0000);
        send_request(plst_pkg::KIND_INSERT, 6'd0, 32'hFFFF_FFFF);
        send_request(plst_pkg::KIND_INSERT, 6'd1, 32'h0000_0000);
        send_request(plst_pkg::KIND_READ, 6'd0, '0);
        send_request(plst_pkg::KIND_READ, 6'd1, '0);
        send_request(plst_pkg::KIND_READ, 6'd3, '0);
        send_request(plst_pkg::KIND_READ, 6'd63, '0);
        send_request(plst_pkg::KIND_DELETE, 6'd63, '0);
        send_request(plst_pkg::KIND_DELETE, 6'd1, '0);
        send_request(plst_pkg::KIND_DELETE, 6'd0, '0);
        send_request(plst_pkg::KIND_READ, 6'd0, '0);
        send_request(KIND_SPARE_MID, 6'd1, 32'hFFFF_FFFF);
        send_request(plst_pkg::KIND_CLEAR, 6'd0, '0);
        send_request(plst_pkg::KIND_READ, 6'd0, '0);
    endtask

    // Fills the list to capacity, pushes past it, then reads and trims the full list.
    task automatic test_fill_to_full();
        logic [KIND_W-1:0] kind;
        while (list_len < CAPACITY) begin
            kind = $urandom_range(0, 1) ? plst_pkg::KIND_APPEND : plst_pkg::KIND_INSERT;
            send_request(kind, POS_W'($urandom), $urandom);
        end
        send_request(plst_pkg::KIND_INSERT, 6'd0, $urandom);
        send_request(plst_pkg::KIND_APPEND, 6'd63, $urandom);
        send_request(plst_pkg::KIND_READ, 6'd63, '0);
        send_request(plst_pkg::KIND_DELETE, 6'd63, '0);
        send_request(plst_pkg::KIND_DELETE, 6'd0, '0);
        send_request(plst_pkg::KIND_INSERT, 6'd63, $urandom);
    endtask

    // Phases of random requests, each with its own mix and with or without idling.
    task automatic test_random_mix(input int unsigned n_items);
        int unsigned sent;
        int unsigned phase_len;
        int unsigned roll;
        int mix;
        int t_ins, t_app, t_del, t_read, t_spare;
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0] pos;
        logic [DATA_W-1:0] val;
        sent = 0;
        while (sent < n_items) begin
            mix = $urandom_range(MIX_GROW, MIX_EVEN);
            phase_len = $urandom_range(20, 150);
            idle_enable = ($urandom_range(0, 3) != 0);
            case (mix)
                MIX_GROW: begin
                    t_ins = 45; t_app = 70; t_del = 80; t_read = 98; t_spare = 99;
                end
                MIX_SHRINK: begin
                    t_ins = 10; t_app = 15; t_del = 70; t_read = 97; t_spare = 99;
                end
                default: begin
                    t_ins = 25; t_app = 35; t_del = 65; t_read = 95; t_spare = 98;
                end
            endcase
            repeat (phase_len) begin
                roll = $urandom_range(0, 99);
                if (roll < t_ins) kind = plst_pkg::KIND_INSERT;
                else if (roll < t_app) kind = plst_pkg::KIND_APPEND;
                else if (roll < t_del) kind = plst_pkg::KIND_DELETE;
                else if (roll < t_read) kind = plst_pkg::KIND_READ;
                else if (roll < t_spare)
                    kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
                else kind = plst_pkg::KIND_CLEAR;
                // Positions mostly fall inside the list or at its end, sometimes anywhere.
                if ($urandom_range(0, 4) == 0 || list_len > 63)
                    pos = POS_W'($urandom);
                else
                    pos = POS_W'($urandom_range(0, list_len));
                case ($urandom_range(0, 19))
                    0: val = 32'h7FFF_FFFF;
                    1: val = 32'h8000_0000;
                    2: val = '0;
                    3: val = 32'hFFFF_FFFF;
                    default: val = $urandom;
                endcase
                send_request(kind, pos, val);
                sent++;
            end
        end
        idle_enable = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_list();
        test_edge_positions();
        test_fill_to_full();
        test_random_mix(RANDOM_ITEMS);

        // Let every result come back, then watch for strays.
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch("missing results, count", '0, DATA_W'(pending_results.size()));

        $display("Sent %0d requests and checked %0d results, with random idling on both sides.",
                 requests_sent, results_checked);
        $display("Results by status: ok %0d, full %0d, past end %0d, empty read %0d.",
                 status_seen[plst_pkg::STAT_OK], status_seen[plst_pkg::STAT_FULL],
                 status_seen[plst_pkg::STAT_PAST_END], status_seen[plst_pkg::STAT_EMPTY]);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
